// ----- rtl/mtrg_pkg.sv -----
// Shared constants and controller/datapath command types for the MT19937 generator.
// No dependencies; every other file in rtl/ refers to this package by scoped name.
`timescale 1ns / 1ps

package mtrg_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned TABLE_DEPTH = 624;
  localparam int unsigned POS_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CFG_INDEX_W = 1;

  localparam logic [POS_W-1:0]  LAST_INDEX = POS_W'(TABLE_DEPTH - 1);
  localparam logic [POS_W-1:0]  SHIFT_M    = POS_W'(397);
  localparam logic [POS_W-1:0]  WRAP_M     = POS_W'(TABLE_DEPTH - 397);

  localparam logic [WORD_W-1:0] INIT_MULT    = 32'd1812433253;
  localparam logic [WORD_W-1:0] MATRIX_A     = 32'h9908b0df;
  localparam logic [WORD_W-1:0] UPPER_MASK   = 32'h80000000;
  localparam logic [WORD_W-1:0] LOWER_MASK   = 32'h7fffffff;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc60000;
  localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd5489;

  localparam logic [WORD_W-1:0] RANGE_LOW_RESET  = 32'h00000000;
  localparam logic [WORD_W-1:0] RANGE_HIGH_RESET = 32'h7fffffff;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_LOW  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_HIGH = 1'b1;

  // request type codes
  localparam logic REQ_DRAW   = 1'b0;
  localparam logic REQ_RESEED = 1'b1;

  typedef struct packed {
    logic seed_load;    // start a fill: write entry 0, clear position
    logic use_default;  // seed source is the power-on seed
    logic fill_step;    // write the next entry of the init recurrence
    logic draw_read;    // fetch the next and far table words
    logic twist;        // regenerate current word, temper, advance position
    logic scale;        // multiply tempered word by the range span
    logic out_load;     // load the result register
  } cmd_t;

  typedef struct packed {
    logic fill_last;    // the entry being filled is the last one
  } status_t;

endpackage

// ----- rtl/mtrg_if.sv -----
// Valid/ready channel interfaces for the MT19937 generator request and result streams.
// Depends on mtrg_pkg for field widths.
`timescale 1ns / 1ps

interface mtrg_req_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [mtrg_pkg::WORD_W-1:0] seed_value;

  modport source (output valid, output req_type, output seed_value, input ready);
  modport sink   (input valid, input req_type, input seed_value, output ready);
endinterface

interface mtrg_rsp_if;
  logic                               valid;
  logic                               ready;
  logic        [mtrg_pkg::WORD_W-1:0] random_word;
  logic signed [mtrg_pkg::WORD_W-1:0] scaled_value;

  modport source (output valid, output random_word, output scaled_value, input ready);
  modport sink   (input valid, input random_word, input scaled_value, output ready);
endinterface

// ----- rtl/mtrg_ctrl.sv -----
// Sequencer for the MT19937 generator: boot seeding, reseed fill, draw steps, result valid.
// Depends on mtrg_pkg for the command and status structs and request codes.
`timescale 1ns / 1ps

module mtrg_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_type,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  input  mtrg_pkg::status_t status,
  output mtrg_pkg::cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_BOOT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_FILL  = 6'b000100,
    S_TWIST = 6'b001000,
    S_SCALE = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   out_valid;
  logic   accept;
  logic   slot_free;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign slot_free = !out_valid || rsp_ready;
  assign rsp_valid = out_valid;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_BOOT: begin
        cmd.seed_load   = 1'b1;
        cmd.use_default = 1'b1;
        state_next      = S_FILL;
      end
      S_IDLE: begin
        if (accept) begin
          if (req_type == mtrg_pkg::REQ_RESEED) begin
            cmd.seed_load = 1'b1;
            state_next    = S_FILL;
          end else begin
            cmd.draw_read = 1'b1;
            state_next    = S_TWIST;
          end
        end
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (status.fill_last) begin
          state_next = S_IDLE;
        end
      end
      S_TWIST: begin
        cmd.twist  = 1'b1;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        // hold until the result register can take the new transaction
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_BOOT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_BOOT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (rsp_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || rsp_ready))
    else $error("result register overwritten while still held");

  a_fill_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL && status.fill_last) |=> (state == S_IDLE))
    else $error("fill did not end after the last entry");

  a_twist_after_read: assert property (@(posedge clk) disable iff (rst)
    cmd.twist |-> $past(cmd.draw_read))
    else $error("twist step without a preceding table read");

  a_result_after_twist: assert property (@(posedge clk) disable iff (rst)
    cmd.twist |=> ##1 (state == S_EMIT))
    else $error("draw did not reach the result step");

endmodule

// ----- rtl/mtrg_datapath.sv -----
// Datapath for the MT19937 generator: state table memory, position, seeding multiplier,
// twist and tempering, range scaling multiplier, configuration and result registers.
// Depends on mtrg_pkg for constants and the command and status structs.
`timescale 1ns / 1ps

module mtrg_datapath (
  input  logic                                     clk,
  input  logic                                     rst,
  input  mtrg_pkg::cmd_t                           cmd,
  output mtrg_pkg::status_t                        status,
  input  logic [mtrg_pkg::WORD_W-1:0]              seed_value,
  input  logic                                     write_enable,
  input  logic [mtrg_pkg::CFG_INDEX_W-1:0]         register_index,
  input  logic [mtrg_pkg::WORD_W-1:0]              write_data,
  output logic [mtrg_pkg::WORD_W-1:0]              random_word,
  output logic signed [mtrg_pkg::WORD_W-1:0]       scaled_value
);

  localparam int unsigned W  = mtrg_pkg::WORD_W;
  localparam int unsigned PW = mtrg_pkg::POS_W;

  logic [W-1:0]  twist_mem [mtrg_pkg::TABLE_DEPTH];

  logic [PW-1:0] pos;
  logic [PW-1:0] pos_nxt;
  logic [PW-1:0] pos_far;
  logic [PW-1:0] fill_idx;

  logic [W-1:0]  head_word;   // copy of the table word at pos
  logic [W-1:0]  rd_nxt;
  logic [W-1:0]  rd_far;
  logic [W-1:0]  seed_word;   // last entry written by the fill

  logic [W-1:0]  range_low;
  logic [W-1:0]  range_high;
  logic [W:0]    span;
  logic          inverted;

  logic [W-1:0]  temper_word;
  logic [W-1:0]  prod_hi;

  logic          wr_en;
  logic [PW-1:0] wr_addr;
  logic [W-1:0]  wr_data;

  logic [W-1:0]  seed_src;
  logic [W-1:0]  seed_mix;
  logic [W-1:0]  seed_next;
  logic [W-1:0]  mix_y;
  logic [W-1:0]  twist_next;
  logic [W:0]    span_next;
  logic [2*W-1:0] prod;
  logic [W-1:0]  offset;
  logic [W-1:0]  scaled_next;

  function automatic logic [W-1:0] temper(input logic [W-1:0] v);
    logic [W-1:0] y;
    y = v ^ (v >> 11);
    y = y ^ ((y << 7) & mtrg_pkg::TEMPER_B);
    y = y ^ ((y << 15) & mtrg_pkg::TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // table neighbors of the current position
  assign pos_nxt = (pos == mtrg_pkg::LAST_INDEX) ? '0 : pos + PW'(1);
  assign pos_far = (pos < mtrg_pkg::WRAP_M) ? pos + mtrg_pkg::SHIFT_M : pos - mtrg_pkg::WRAP_M;

  assign status.fill_last = (fill_idx == mtrg_pkg::LAST_INDEX);

  always_comb begin
    seed_src   = cmd.use_default ? mtrg_pkg::DEFAULT_SEED : seed_value;
    seed_mix   = seed_word ^ (seed_word >> 30);
    seed_next  = (seed_mix * mtrg_pkg::INIT_MULT) + {{(W-PW){1'b0}}, fill_idx};
    mix_y      = (head_word & mtrg_pkg::UPPER_MASK) | (rd_nxt & mtrg_pkg::LOWER_MASK);
    twist_next = rd_far ^ (mix_y >> 1) ^ (mix_y[0] ? mtrg_pkg::MATRIX_A : '0);
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_data = twist_next;
    if (cmd.seed_load) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = seed_src;
    end else if (cmd.fill_step) begin
      wr_en   = 1'b1;
      wr_addr = fill_idx;
      wr_data = seed_next;
    end else if (cmd.twist) begin
      wr_en   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      twist_mem[wr_addr] <= wr_data;
    end
    if (cmd.draw_read) begin
      rd_nxt <= twist_mem[pos_nxt];
      rd_far <= twist_mem[pos_far];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      fill_idx <= PW'(1);
    end else if (cmd.seed_load) begin
      pos      <= '0;
      fill_idx <= PW'(1);
    end else if (cmd.fill_step) begin
      fill_idx <= fill_idx + PW'(1);
    end else if (cmd.twist) begin
      pos <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seed_load) begin
      seed_word <= seed_src;
      head_word <= seed_src;
    end else if (cmd.fill_step) begin
      seed_word <= seed_next;
    end else if (cmd.twist) begin
      // the next word was read this draw and is untouched by the write
      head_word   <= rd_nxt;
      temper_word <= temper(twist_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      range_low  <= mtrg_pkg::RANGE_LOW_RESET;
      range_high <= mtrg_pkg::RANGE_HIGH_RESET;
    end else if (write_enable) begin
      unique case (register_index)
        mtrg_pkg::REG_RANGE_LOW:  range_low  <= write_data;
        mtrg_pkg::REG_RANGE_HIGH: range_high <= write_data;
        default: ;
      endcase
    end
  end

  // span is precomputed from the range registers so the scale step is one multiply
  assign span_next = ({range_high[W-1], range_high} - {range_low[W-1], range_low}) + (W+1)'(1);

  always_ff @(posedge clk) begin
    span     <= span_next;
    inverted <= ($signed(range_high) < $signed(range_low));
  end

  assign prod = {{W{1'b0}}, temper_word} * {{W{1'b0}}, span[W-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      prod_hi <= prod[2*W-1:W];
    end
  end

  // a span of 2^32 leaves the word itself as offset
  assign offset      = span[W] ? temper_word : prod_hi;
  assign scaled_next = inverted ? range_low : (range_low + offset);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      random_word  <= temper_word;
      scaled_value <= $signed(scaled_next);
    end
  end

  a_pos_in_table: assert property (@(posedge clk) disable iff (rst)
    pos <= mtrg_pkg::LAST_INDEX)
    else $error("position left the table");

  a_fill_idx_in_table: assert property (@(posedge clk) disable iff (rst)
    cmd.fill_step |-> (fill_idx != '0 && fill_idx <= mtrg_pkg::LAST_INDEX))
    else $error("fill index out of range");

endmodule

// ----- rtl/mt19937_random_generator_top.sv -----
// MT19937 generator, 32-bit output with range scaling. A draw holds the block until its
// result is loaded, so the next request is accepted only after that load. The four steps are
// a registered two-address read of the state table, the twist with write-back and
// tempering, the 32x32 span multiply, and the result register load. The load waits while
// the previous result is still held, and the valid flag is set by the same load.
// A reseed, and the seeding from 5489 after reset, writes entry 0 of the 624-entry table
// with the seed and fills the rest one entry per cycle through the init multiplier. No
// request is taken until the last entry is written, after a reseed or after reset.
// Configuration writes are taken on any cycle. Depends on mtrg_pkg, mtrg_if, mtrg_ctrl
// and mtrg_datapath.
`timescale 1ns / 1ps

module mt19937_random_generator_top (
  input  logic                                clk,
  input  logic                                rst,
  mtrg_req_if.sink                            request,
  mtrg_rsp_if.source                          result,
  input  logic                                write_enable,
  input  logic [mtrg_pkg::CFG_INDEX_W-1:0]    register_index,
  input  logic [mtrg_pkg::WORD_W-1:0]         write_data
);

  mtrg_pkg::cmd_t    cmd;
  mtrg_pkg::status_t status;

  mtrg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_type  (request.req_type),
    .req_ready (request.ready),
    .rsp_valid (result.valid),
    .rsp_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  mtrg_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .seed_value     (request.seed_value),
    .write_enable   (write_enable),
    .register_index (register_index),
    .write_data     (write_data),
    .random_word    (result.random_word),
    .scaled_value   (result.scaled_value)
  );

endmodule

// ----- sim/tb_mt19937_random_generator_top.sv -----
// Self-checking testbench for mt19937_random_generator_top: directed seeds and ranges,
// a run long enough to wrap the far table index, then a random draw/reseed mix.
// Depends on rtl/mtrg_pkg.sv, rtl/mtrg_if.sv and the generator RTL.
`timescale 1ns / 1ps

module tb_mt19937_random_generator_top;

  localparam int unsigned WORD_W       = mtrg_pkg::WORD_W;
  localparam int unsigned TABLE_DEPTH  = mtrg_pkg::TABLE_DEPTH;
  localparam int unsigned CFG_INDEX_W  = mtrg_pkg::CFG_INDEX_W;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned FILL_SETTLE  = TABLE_DEPTH + 16;
  localparam int unsigned DRAW_SETTLE  = 8;
  localparam int unsigned MAX_IDLE     = 8;
  localparam int unsigned WRAP_DRAWS   = 250;
  localparam int unsigned MIX_DRAWS    = 24;

  typedef struct {
    logic [WORD_W-1:0]        random_word;
    logic signed [WORD_W-1:0] scaled_value;
  } draw_result_t;

  typedef enum int {
    RANGE_FULL, RANGE_NARROW, RANGE_ANY, RANGE_SMALL_POS, RANGE_INVERTED
  } range_mode_t;

  logic                   clk;
  logic                   rst;
  logic                   write_enable;
  logic [CFG_INDEX_W-1:0] register_index;
  logic [WORD_W-1:0]      write_data;

  mtrg_req_if request_ch ();
  mtrg_rsp_if result_ch ();

  mt19937_random_generator_top u_dut (
    .clk            (clk),
    .rst            (rst),
    .request        (request_ch),
    .result         (result_ch),
    .write_enable   (write_enable),
    .register_index (register_index),
    .write_data     (write_data)
  );

  // generator state as the testbench sees it
  logic [WORD_W-1:0]        mt_table [0:TABLE_DEPTH-1];
  int unsigned              mt_pos;
  logic signed [WORD_W-1:0] range_lo;
  logic signed [WORD_W-1:0] range_hi;

  draw_result_t draw_results_q [$];

  int unsigned cycle_count     = 0;
  int unsigned mismatch_count  = 0;
  int unsigned results_checked = 0;
  int unsigned draws_sent      = 0;
  int unsigned reseeds_sent    = 0;
  int unsigned ranges_set      = 0;
  bit          fill_pending    = 1'b1;
  bit          no_idle         = 1'b0;

  initial begin : clock_gen
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, draw_results_q.size());
      $display("tb_mt19937_random_generator_top: FAIL");
      $finish;
    end
  end

  function automatic void mt_seed_table(logic [WORD_W-1:0] seed);
    logic [WORD_W-1:0] prev;
    mt_table[0] = seed;
    for (int i = 1; i < TABLE_DEPTH; i++) begin
      prev = mt_table[i-1];
      mt_table[i] = mtrg_pkg::INIT_MULT * (prev ^ (prev >> 30)) + WORD_W'(i);
    end
    mt_pos = 0;
  endfunction

  // regenerate the word at the position, advance, temper
  function automatic logic [WORD_W-1:0] mt_draw_word();
    int unsigned       cur;
    int unsigned       nxt;
    int unsigned       far_idx;
    logic [WORD_W-1:0] y;
    cur     = mt_pos;
    nxt     = (cur + 1 < TABLE_DEPTH) ? cur + 1 : 0;
    far_idx = cur + int'(mtrg_pkg::SHIFT_M);
    if (far_idx >= TABLE_DEPTH) far_idx -= TABLE_DEPTH;
    y = (mt_table[cur] & mtrg_pkg::UPPER_MASK) | (mt_table[nxt] & mtrg_pkg::LOWER_MASK);
    y = mt_table[far_idx] ^ (y >> 1) ^ (y[0] ? mtrg_pkg::MATRIX_A : '0);
    mt_table[cur] = y;
    mt_pos = nxt;
    y ^= y >> 11;
    y ^= (y << 7) & mtrg_pkg::TEMPER_B;
    y ^= (y << 15) & mtrg_pkg::TEMPER_C;
    y ^= y >> 18;
    return y;
  endfunction

  function automatic logic [WORD_W-1:0] scale_into_range(logic [WORD_W-1:0] word);
    longint      lo_v;
    longint      hi_v;
    logic [63:0] span;
    logic [63:0] prod;
    lo_v = longint'(range_lo);
    hi_v = longint'(range_hi);
    if (hi_v < lo_v) return range_lo;
    span = 64'(hi_v - lo_v + 1);
    prod = {32'b0, word} * span;
    return range_lo + prod[63:32];
  endfunction

  task automatic report_mismatch(string what, logic [WORD_W-1:0] want,
                                 logic [WORD_W-1:0] got);
    $display("[%0t] mismatch %s: expected %h got %h", $time, what, want, got);
    mismatch_count++;
  endtask

  // result side: random stalls on ready, compare each transaction with the oldest draw
  initial begin : result_checker
    int unsigned  stall;
    draw_result_t want;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall != 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk);
      while (rst !== 1'b0 || result_ch.valid !== 1'b1 || result_ch.ready !== 1'b1);
      if (draw_results_q.size() == 0) begin
        report_mismatch("result with no draw pending", '0, result_ch.random_word);
      end else begin
        want = draw_results_q.pop_front();
        if (result_ch.random_word !== want.random_word)
          report_mismatch("random_word", want.random_word, result_ch.random_word);
        if (result_ch.scaled_value !== want.scaled_value)
          report_mismatch("scaled_value", want.scaled_value, result_ch.scaled_value);
        results_checked++;
      end
    end
  end

  // returns in the step of acceptance with valid still high; the caller either sends
  // again or drops valid in that same step
  task automatic send_item(logic req_type, logic [WORD_W-1:0] seed);
    int unsigned  gap;
    draw_result_t exp_result;
    gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap != 0) begin
      request_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request_ch.valid      <= 1'b1;
    request_ch.req_type   <= req_type;
    request_ch.seed_value <= seed;
    do @(posedge clk); while (request_ch.ready !== 1'b1);
    if (req_type == mtrg_pkg::REQ_RESEED) begin
      mt_seed_table(seed);
      reseeds_sent++;
      fill_pending = 1'b1;
    end else begin
      exp_result.random_word  = mt_draw_word();
      exp_result.scaled_value = scale_into_range(exp_result.random_word);
      draw_results_q.push_back(exp_result);
      draws_sent++;
      fill_pending = 1'b0;
    end
  endtask

  task automatic send_draw();
    send_item(mtrg_pkg::REQ_DRAW, $urandom());
  endtask

  task automatic wait_drained();
    request_ch.valid <= 1'b0;
    while (draw_results_q.size() != 0) @(posedge clk);
  endtask

  // a reseed gives no result, so a fill may still be running after the queue empties
  task automatic settle();
    repeat (fill_pending ? FILL_SETTLE : DRAW_SETTLE) @(posedge clk);
  endtask

  task automatic program_range(logic [WORD_W-1:0] lo, logic [WORD_W-1:0] hi);
    wait_drained();
    settle();
    write_enable   <= 1'b1;
    register_index <= mtrg_pkg::REG_RANGE_LOW;
    write_data     <= lo;
    @(posedge clk);
    register_index <= mtrg_pkg::REG_RANGE_HIGH;
    write_data     <= hi;
    @(posedge clk);
    write_enable <= 1'b0;
    range_lo = lo;
    range_hi = hi;
    ranges_set++;
  endtask

  function automatic logic [WORD_W-1:0] pick_seed();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic test_reset_seed();
    repeat (3) send_draw();
  endtask

  task automatic test_reseed_values();
    send_item(mtrg_pkg::REQ_RESEED, 32'h0000_0000);
    send_draw();
    send_draw();
    send_item(mtrg_pkg::REQ_RESEED, 32'hffff_ffff);
    send_draw();
    // back-to-back reseeds: only the second must count
    send_item(mtrg_pkg::REQ_RESEED, $urandom());
    send_item(mtrg_pkg::REQ_RESEED, mtrg_pkg::DEFAULT_SEED);
    send_draw();
  endtask

  task automatic test_range_corners();
    logic [WORD_W-1:0] corner_lo [7] = '{32'h8000_0000, 32'h0, 32'h7fff_ffff,
                                         32'h8000_0000, 32'd5, 32'h7fff_ffff,
                                         32'hffff_ffff};
    logic [WORD_W-1:0] corner_hi [7] = '{32'h7fff_ffff, 32'h0, 32'h7fff_ffff,
                                         32'h8000_0000, -32'sd5, 32'h8000_0000,
                                         32'h0};
    for (int k = 0; k < 7; k++) begin
      program_range(corner_lo[k], corner_hi[k]);
      send_draw();
      send_draw();
    end
  endtask

  // enough draws after a reseed that the far index wraps past the table end
  task automatic test_table_wrap();
    program_range(32'h8000_0000, 32'h7fff_ffff);
    send_item(mtrg_pkg::REQ_RESEED, $urandom());
    for (int k = 0; k < WRAP_DRAWS; k++) begin
      if (k % 50 == 0) no_idle = ($urandom_range(0, 2) == 0);
      send_draw();
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random_mix();
    range_mode_t       mode;
    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] hi;
    for (int phase = 0; phase < 6; phase++) begin
      mode = range_mode_t'($urandom_range(0, 4));
      case (mode)
        RANGE_FULL: begin
          lo = 32'h8000_0000;
          hi = 32'h7fff_ffff;
        end
        RANGE_NARROW: begin
          lo = $urandom();
          hi = lo + $urandom_range(0, 15);
        end
        RANGE_SMALL_POS: begin
          lo = $urandom_range(0, 1000);
          hi = lo + $urandom_range(0, 100000);
        end
        RANGE_INVERTED: begin
          hi = $urandom();
          lo = hi + 1 + $urandom_range(0, 99);
        end
        default: begin
          lo = $urandom();
          hi = $urandom();
        end
      endcase
      program_range(lo, hi);
      for (int k = 0; k < MIX_DRAWS; k++) begin
        if (k % 8 == 0) no_idle = ($urandom_range(0, 3) == 0);
        // hold the sender until the result side has caught up
        if ((phase == 0 && k == 12) || $urandom_range(0, 39) == 0) wait_drained();
        if ($urandom_range(0, 19) == 0) send_item(mtrg_pkg::REQ_RESEED, pick_seed());
        else send_draw();
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin : main_seq
    rst                   <= 1'b1;
    write_enable          <= 1'b0;
    register_index        <= mtrg_pkg::REG_RANGE_LOW;
    write_data            <= '0;
    request_ch.valid      <= 1'b0;
    request_ch.req_type   <= mtrg_pkg::REQ_DRAW;
    request_ch.seed_value <= '0;
    range_lo = mtrg_pkg::RANGE_LOW_RESET;
    range_hi = mtrg_pkg::RANGE_HIGH_RESET;
    mt_seed_table(mtrg_pkg::DEFAULT_SEED);
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_reset_seed();
    test_reseed_values();
    test_range_corners();
    test_table_wrap();
    test_random_mix();

    wait_drained();
    settle();
    if (draw_results_q.size() != 0)
      report_mismatch("draws left without a result", '0, draw_results_q.size());
    $display("covered %0d draws and %0d reseeds over %0d range settings",
             draws_sent, reseeds_sent, ranges_set);
    $display("%0d results checked, %0d mismatches, %0d cycles",
             results_checked, mismatch_count, cycle_count);
    if (mismatch_count == 0) begin
      $display("tb_mt19937_random_generator_top: PASS");
    end else begin
      $display("tb_mt19937_random_generator_top: FAIL");
    end
    $finish;
  end

endmodule

// ----- mt19937_random_generator_top.f -----
rtl/mtrg_pkg.sv
rtl/mtrg_if.sv
rtl/mtrg_ctrl.sv
rtl/mtrg_datapath.sv
rtl/mt19937_random_generator_top.sv
sim/tb_mt19937_random_generator_top.sv
